>>> hw/rtl/spdb_pkg.sv
// ----------------------------------------------------------------------------
// spdb_pkg
// shared types and constants of the slot pool double buffer manager
// ----------------------------------------------------------------------------
`default_nettype none

package spdb_pkg;

    localparam int SLOT_W    = 10;
    localparam int MARK_W    = 11;
    localparam int CNT_OUT_W = 11;
    localparam int CTR_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [MARK_W-1:0] FREE_LOW_MARK_RST     = 11'd64;
    localparam logic [MARK_W-1:0] WRITTEN_HIGH_MARK_RST = 11'd512;

    localparam logic [CFG_IDX_W-1:0] REG_FREE_LOW_MARK     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITTEN_HIGH_MARK = 2'd1;

    typedef enum logic [2:0] {
        CMD_ALLOC     = 3'd0,
        CMD_COMMIT    = 3'd1,
        CMD_CANCEL    = 3'd2,
        CMD_SWAP      = 3'd3,
        CMD_RESTART   = 3'd4,
        CMD_READ_LINK = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_LINK
    } state_t;

    typedef struct packed {
        cmd_t              command;
        logic [SLOT_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic                 success;
        logic [SLOT_W-1:0]    slot_out;
        logic [CTR_W-1:0]     serial_out;
        logic [SLOT_W-1:0]    reading_first;
        logic [CNT_OUT_W-1:0] reading_total;
        logic [CNT_OUT_W-1:0] free_total;
        logic [CNT_OUT_W-1:0] written_total;
        logic [CTR_W-1:0]     drop_total;
        logic                 ready_flag;
    } rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/slot_pool_double_buffer_manager_core.sv
// ----------------------------------------------------------------------------
// slot_pool_double_buffer_manager_core
// free / written / reading slot lists threaded through one link memory
// ----------------------------------------------------------------------------
// A request is accepted in ST_IDLE, where the link memory read is issued, and
// the state and memory are updated in ST_EXEC. A commit to a non-empty
// written list also passes through ST_LINK, since it writes two links through
// the single write port. After reset and after a restart command the link
// memory is relinked by a clearing pass over all POOL_SLOTS slots (1024 by
// default) during which req_ready stays low; configuration writes are taken
// at any time. One result is returned per request, in order; a finished
// result may wait in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pool_double_buffer_manager_core #(
    parameter int POOL_SLOTS = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire spdb_pkg::req_t                   req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output spdb_pkg::rsp_t                        rsp,
    input  wire logic                             cfg_en,
    input  wire logic [spdb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [spdb_pkg::MARK_W-1:0]      cfg_data
);

    import spdb_pkg::*;

    localparam int AW = $clog2(POOL_SLOTS);
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam int CW = LW;
    localparam logic [LW-1:0] LINK_END  = LW'(POOL_SLOTS);
    localparam logic [CW-1:0] POOL_CNT  = CW'(POOL_SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SLOTS - 1);

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, POOL_CNT})
        begin
            return POOL_CNT;
        end
        return s[CW-1:0];
    endfunction

    state_t          state_reg, state_next;
    req_t            cur_reg, cur_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [LW-1:0]   free_first_reg, free_first_next;
    logic [CW-1:0]   free_count_reg, free_count_next;
    logic [AW-1:0]   written_first_reg, written_first_next;
    logic [AW-1:0]   written_last_reg, written_last_next;
    logic [CW-1:0]   written_count_reg, written_count_next;
    logic [AW-1:0]   reading_head_reg, reading_head_next;
    logic [AW-1:0]   reading_last_reg, reading_last_next;
    logic [CW-1:0]   reading_count_reg, reading_count_next;
    logic [CTR_W-1:0] serial_reg, serial_next;
    logic [CTR_W-1:0] drop_reg, drop_next;
    logic            attention_reg, attention_next;
    logic [AW-1:0]   link_addr_reg, link_addr_next;
    logic [LW-1:0]   link_data_reg, link_data_next;
    logic [MARK_W-1:0] free_low_mark_reg, written_high_mark_reg;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_reg, out_next;
    logic            pend_valid_reg, pend_valid_next;
    rsp_t            pend_reg, pend_next;

    logic            accept;
    logic            in_range;
    logic [AW-1:0]   slot_addr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [LW-1:0]   mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [LW-1:0]   mem_rdata;
    logic            res_ok;
    logic [LW-1:0]   res_slot;
    logic [CTR_W-1:0] res_serial;
    rsp_t            res_cur;
    logic            out_free;

    assign accept    = req_valid && req_ready;
    assign slot_addr = AW'(cur_reg.slot_index);
    assign in_range  = (32'(cur_reg.slot_index) < 32'(POOL_SLOTS));
    assign mem_raddr = (req.command == CMD_ALLOC) ? AW'(free_first_reg)
                                                  : AW'(req.slot_index);

    spdb_link_mem #(
        .DEPTH (POOL_SLOTS),
        .AW    (AW),
        .DW    (LW)
    ) u_link_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cur_reg.command == CMD_RESTART)
                begin
                    state_next = ST_CLEAR;
                end
                else if (cur_reg.command == CMD_COMMIT && in_range &&
                         written_count_reg != '0)
                begin
                    state_next = ST_LINK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LINK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state machine outputs: handshake and link memory writes
    always_comb
    begin
        req_ready = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = slot_addr;
        mem_wdata = LINK_END;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = LW'(clr_cnt_reg) + LW'(1);
            end
            ST_IDLE:
            begin
                req_ready = !pend_valid_reg;
            end
            ST_EXEC:
            begin
                unique case (cur_reg.command)
                    CMD_COMMIT:
                    begin
                        mem_we = in_range;
                    end
                    CMD_CANCEL:
                    begin
                        mem_we    = in_range;
                        mem_wdata = free_first_reg;
                    end
                    CMD_SWAP:
                    begin
                        mem_we    = (reading_count_reg != '0);
                        mem_waddr = reading_last_reg;
                        mem_wdata = free_first_reg;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            ST_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = link_addr_reg;
                mem_wdata = link_data_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // list and counter updates
    always_comb
    begin
        cur_next           = cur_reg;
        clr_cnt_next       = clr_cnt_reg;
        free_first_next    = free_first_reg;
        free_count_next    = free_count_reg;
        written_first_next = written_first_reg;
        written_last_next  = written_last_reg;
        written_count_next = written_count_reg;
        reading_head_next  = reading_head_reg;
        reading_last_next  = reading_last_reg;
        reading_count_next = reading_count_reg;
        serial_next        = serial_reg;
        drop_next          = drop_reg;
        attention_next     = attention_reg;
        link_addr_next     = link_addr_reg;
        link_data_next     = link_data_reg;
        res_ok             = 1'b0;
        res_slot           = '0;
        res_serial         = '0;

        if (accept)
        begin
            cur_next = req;
        end

        if (state_reg == ST_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        if (state_reg == ST_EXEC)
        begin
            unique case (cur_reg.command)
                CMD_ALLOC:
                begin
                    if (free_count_reg == '0 || free_first_reg >= LINK_END)
                    begin
                        drop_next = drop_reg + CTR_W'(1);
                    end
                    else
                    begin
                        res_ok          = 1'b1;
                        res_slot        = free_first_reg;
                        free_first_next = mem_rdata;
                        free_count_next = free_count_reg - CW'(1);
                    end
                end
                CMD_COMMIT:
                begin
                    if (in_range)
                    begin
                        serial_next = serial_reg + CTR_W'(1);
                        res_serial  = serial_next;
                        if (written_count_reg == '0)
                        begin
                            written_first_next = slot_addr;
                        end
                        // old tail of a non-empty written list gets linked in the next cycle
                        link_addr_next     = written_last_reg;
                        link_data_next     = LW'(slot_addr);
                        written_last_next  = slot_addr;
                        written_count_next = sat_add(written_count_reg, CW'(1));
                        if (32'(free_count_reg) < 32'(free_low_mark_reg) ||
                            32'(written_count_next) > 32'(written_high_mark_reg))
                        begin
                            attention_next = 1'b1;
                        end
                    end
                end
                CMD_CANCEL:
                begin
                    if (in_range)
                    begin
                        free_first_next = LW'(slot_addr);
                        free_count_next = sat_add(free_count_reg, CW'(1));
                    end
                end
                CMD_SWAP:
                begin
                    if (reading_count_reg != '0)
                    begin
                        free_first_next = LW'(reading_head_reg);
                        free_count_next = sat_add(free_count_reg, reading_count_reg);
                    end
                    reading_head_next  = written_first_reg;
                    reading_last_next  = written_last_reg;
                    reading_count_next = written_count_reg;
                    written_first_next = '0;
                    written_last_next  = '0;
                    written_count_next = '0;
                    attention_next     = 1'b0;
                end
                CMD_RESTART:
                begin
                    clr_cnt_next       = '0;
                    free_first_next    = '0;
                    free_count_next    = POOL_CNT;
                    written_first_next = '0;
                    written_last_next  = '0;
                    written_count_next = '0;
                    reading_head_next  = '0;
                    reading_last_next  = '0;
                    reading_count_next = '0;
                    serial_next        = '0;
                    drop_next          = '0;
                    attention_next     = 1'b0;
                end
                CMD_READ_LINK:
                begin
                    if (in_range && mem_rdata < LINK_END)
                    begin
                        res_ok   = 1'b1;
                        res_slot = mem_rdata;
                    end
                end
                default:
                begin
                    res_ok = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        res_cur.success       = res_ok;
        res_cur.slot_out      = SLOT_W'(res_slot);
        res_cur.serial_out    = res_serial;
        res_cur.reading_first = (reading_count_next != '0) ? SLOT_W'(reading_head_next)
                                                           : '0;
        res_cur.reading_total = CNT_OUT_W'(reading_count_next);
        res_cur.free_total    = CNT_OUT_W'(free_count_next);
        res_cur.written_total = CNT_OUT_W'(written_count_next);
        res_cur.drop_total    = drop_next;
        res_cur.ready_flag    = attention_next;
    end

    // output register with one pending entry behind it
    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (state_reg == ST_EXEC)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_next       = res_cur;
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_next       = res_cur;
            end
        end
        else if (pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
        else if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            free_first_reg    <= '0;
            free_count_reg    <= POOL_CNT;
            written_first_reg <= '0;
            written_last_reg  <= '0;
            written_count_reg <= '0;
            reading_head_reg  <= '0;
            reading_last_reg  <= '0;
            reading_count_reg <= '0;
            serial_reg        <= '0;
            drop_reg          <= '0;
            attention_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            pend_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_cnt_reg       <= clr_cnt_next;
            free_first_reg    <= free_first_next;
            free_count_reg    <= free_count_next;
            written_first_reg <= written_first_next;
            written_last_reg  <= written_last_next;
            written_count_reg <= written_count_next;
            reading_head_reg  <= reading_head_next;
            reading_last_reg  <= reading_last_next;
            reading_count_reg <= reading_count_next;
            serial_reg        <= serial_next;
            drop_reg          <= drop_next;
            attention_reg     <= attention_next;
            out_valid_reg     <= out_valid_next;
            pend_valid_reg    <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        link_addr_reg <= link_addr_next;
        link_data_reg <= link_data_next;
        out_reg       <= out_next;
        pend_reg      <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_low_mark_reg     <= FREE_LOW_MARK_RST;
            written_high_mark_reg <= WRITTEN_HIGH_MARK_RST;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                REG_FREE_LOW_MARK:     free_low_mark_reg     <= cfg_data;
                REG_WRITTEN_HIGH_MARK: written_high_mark_reg <= cfg_data;
                default:
                begin
                    free_low_mark_reg <= free_low_mark_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/spdb_link_mem.sv
// ----------------------------------------------------------------------------
// spdb_link_mem
// link memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module spdb_link_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/spdb_checker.sv
// ----------------------------------------------------------------------------
// spdb_checker
// port-level checks of the slot pool double buffer manager
// ----------------------------------------------------------------------------
`default_nettype none

module spdb_checker #(
    parameter int POOL_SLOTS = 1024
) (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire spdb_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire spdb_pkg::rsp_t rsp
);

    import spdb_pkg::*;

    localparam bit SMALL_POOL = (POOL_SLOTS < 2048);

    // a result that is not taken stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // one request at a time: no back-to-back acceptance
    a_req_gap: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted in consecutive cycles");

    // counts saturate at the pool size
    a_free_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !SMALL_POOL || (32'(rsp.free_total) <= 32'(POOL_SLOTS) &&
                      32'(rsp.written_total) <= 32'(POOL_SLOTS) &&
                      32'(rsp.reading_total) <= 32'(POOL_SLOTS)))
        else $error("list count above pool size");

    // an empty reading list reports head zero
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.reading_total == '0 |-> !SMALL_POOL || rsp.reading_first == '0)
        else $error("empty reading list with nonzero head");

endmodule

bind slot_pool_double_buffer_manager_core spdb_checker #(
    .POOL_SLOTS (POOL_SLOTS)
) u_spdb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

>>> bench/slot_pool_double_buffer_manager_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_double_buffer_manager_core_checker
// watches both channels and the mark writes, keeps a shadow of the three
// slot lists and compares every response with the predicted one, in order
// ----------------------------------------------------------------------------
module slot_pool_double_buffer_manager_core_checker
    import spdb_pkg::*;
#(
    parameter int POOL = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  req_t                 req,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  rsp_t                 rsp,
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MARK_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   req_total,
    output int                   rsp_total
);

    localparam logic [MARK_W-1:0] LINK_END = MARK_W'(POOL);

    // shadow of the link memory and list heads, 11 bits so the end mark fits
    logic [MARK_W-1:0] link_mem [POOL];
    logic [MARK_W-1:0] free_top;
    logic [MARK_W-1:0] wr_first;
    logic [MARK_W-1:0] wr_last;
    logic [MARK_W-1:0] rd_first;
    logic [MARK_W-1:0] rd_last;
    int unsigned       free_cnt;
    int unsigned       wr_cnt;
    int unsigned       rd_cnt;
    logic [CTR_W-1:0]  serial_ctr;
    logic [CTR_W-1:0]  drop_ctr;
    logic              attn;
    logic [MARK_W-1:0] low_mark;
    logic [MARK_W-1:0] high_mark;

    rsp_t expected_rsp [$];
    int   fails = 0;
    int   reqs_seen = 0;
    int   rsps_seen = 0;

    function automatic int unsigned add_capped(input int unsigned a, input int unsigned b);
        return (a + b > POOL) ? POOL : a + b;
    endfunction

    task automatic relink_pool();
        for (int i = 0; i < POOL; i++)
        begin
            link_mem[i] = MARK_W'(i + 1);
        end
        free_top = '0;
        free_cnt = POOL;
        wr_first = '0;
        wr_last = '0;
        wr_cnt = 0;
        rd_first = '0;
        rd_last = '0;
        rd_cnt = 0;
        serial_ctr = '0;
        drop_ctr = '0;
        attn = 1'b0;
    endtask

    task automatic predict_pool_op(input req_t r, output rsp_t o);
        logic [MARK_W-1:0] slot;
        logic              ok;
        logic [MARK_W-1:0] slot_res;
        logic [CTR_W-1:0]  serial_res;
        slot = MARK_W'(r.slot_index);
        ok = 1'b0;
        slot_res = '0;
        serial_res = '0;
        case (r.command)
            CMD_ALLOC:
            begin
                // broken free head behaves like an empty pool
                if (free_cnt == 0 || free_top >= LINK_END)
                begin
                    drop_ctr = drop_ctr + 1;
                end
                else
                begin
                    slot_res = free_top;
                    free_top = link_mem[free_top];
                    free_cnt = free_cnt - 1;
                    ok = 1'b1;
                end
            end
            CMD_COMMIT:
            begin
                if (slot < LINK_END)
                begin
                    link_mem[slot] = LINK_END;
                    serial_ctr = serial_ctr + 1;
                    serial_res = serial_ctr;
                    if (wr_cnt == 0)
                        wr_first = slot;
                    else if (wr_last < LINK_END)
                        link_mem[wr_last] = slot;
                    wr_last = slot;
                    wr_cnt = add_capped(wr_cnt, 1);
                    if (free_cnt < low_mark || wr_cnt > high_mark)
                        attn = 1'b1;
                end
            end
            CMD_CANCEL:
            begin
                if (slot < LINK_END)
                begin
                    link_mem[slot] = free_top;
                    free_top = slot;
                    free_cnt = add_capped(free_cnt, 1);
                end
            end
            CMD_SWAP:
            begin
                // old reading list goes back on top of the free stack
                if (rd_cnt != 0)
                begin
                    if (rd_last < LINK_END)
                        link_mem[rd_last] = free_top;
                    free_top = rd_first;
                    free_cnt = add_capped(free_cnt, rd_cnt);
                end
                rd_first = wr_first;
                rd_last = wr_last;
                rd_cnt = wr_cnt;
                wr_first = '0;
                wr_last = '0;
                wr_cnt = 0;
                attn = 1'b0;
            end
            CMD_RESTART:
            begin
                relink_pool();
            end
            CMD_READ_LINK:
            begin
                if (slot < LINK_END && link_mem[slot] < LINK_END)
                begin
                    ok = 1'b1;
                    slot_res = link_mem[slot];
                end
            end
            default:
            begin
            end
        endcase
        o.success = ok;
        o.slot_out = slot_res[SLOT_W-1:0];
        o.serial_out = serial_res;
        o.reading_first = (rd_cnt != 0) ? rd_first[SLOT_W-1:0] : '0;
        o.reading_total = CNT_OUT_W'(rd_cnt);
        o.free_total = CNT_OUT_W'(free_cnt);
        o.written_total = CNT_OUT_W'(wr_cnt);
        o.drop_total = drop_ctr;
        o.ready_flag = attn;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t want;
        rsp_t next_rsp;
        if (!rst_n)
        begin
            relink_pool();
            low_mark = FREE_LOW_MARK_RST;
            high_mark = WRITTEN_HIGH_MARK_RST;
            expected_rsp.delete();
        end
        else
        begin
            if (cfg_en)
            begin
                if (cfg_index == REG_FREE_LOW_MARK)
                    low_mark = cfg_data;
                else if (cfg_index == REG_WRITTEN_HIGH_MARK)
                    high_mark = cfg_data;
            end
            // a response taken now always belongs to an earlier request
            if (rsp_valid && rsp_ready)
            begin
                rsps_seen++;
                if (expected_rsp.size() == 0)
                begin
                    fails++;
                    $display("%0t: response with no request outstanding, expected none, got %p",
                             $time, rsp);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("success", 32'(want.success), 32'(rsp.success));
                    check_field("slot_out", 32'(want.slot_out), 32'(rsp.slot_out));
                    check_field("serial_out", want.serial_out, rsp.serial_out);
                    check_field("reading_first", 32'(want.reading_first),
                                32'(rsp.reading_first));
                    check_field("reading_total", 32'(want.reading_total),
                                32'(rsp.reading_total));
                    check_field("free_total", 32'(want.free_total), 32'(rsp.free_total));
                    check_field("written_total", 32'(want.written_total),
                                32'(rsp.written_total));
                    check_field("drop_total", want.drop_total, rsp.drop_total);
                    check_field("ready_flag", 32'(want.ready_flag), 32'(rsp.ready_flag));
                end
            end
            if (req_valid && req_ready)
            begin
                reqs_seen++;
                predict_pool_op(req, next_rsp);
                expected_rsp.push_back(next_rsp);
            end
        end
        fail_count <= fails;
        pending <= expected_rsp.size();
        req_total <= reqs_seen;
        rsp_total <= rsps_seen;
    end

endmodule

>>> bench/slot_pool_double_buffer_manager_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_double_buffer_manager_core_test
// drives directed and random pool requests through the manager under several
// mark settings, with bursty requests and a stalling consumer; the checker
// beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module slot_pool_double_buffer_manager_core_test;
    import spdb_pkg::*;

    localparam int POOL           = 1024;
    localparam int PHASES         = 6;
    localparam int PHASE_REQUESTS = 150;
    localparam int HISTORY_DEPTH  = 64;
    // a restart clears all POOL slots of the link memory with nothing accepted
    localparam int WATCHDOG_LIMIT = 4 * (POOL + 200);

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MARK_W-1:0]    cfg_data = '0;

    int fail_count;
    int pending_count;
    int req_total;
    int rsp_total;

    // sender side bookkeeping, all touched from the stimulus process only
    cmd_t              outstanding [$];
    logic [SLOT_W-1:0] owned [$];
    logic [SLOT_W-1:0] committed [$];
    bit                req_taken = 1'b0;
    int                burst_left = 0;
    int                mark_settings = 0;

    int quiet_cycles = 0;
    int ready_mode = 0;
    int ready_phase = 0;

    always #2 clk = ~clk;

    slot_pool_double_buffer_manager_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slot_pool_double_buffer_manager_core_checker #(
        .POOL (POOL)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_en     (cfg_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending_count),
        .req_total  (req_total),
        .rsp_total  (rsp_total)
    );

    // consumer stalls: switch pattern each time ready_phase wraps
    always @(posedge clk)
    begin
        ready_phase <= (ready_phase == 63) ? 0 : ready_phase + 1;
        if (ready_phase == 63)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (ready_phase % 4 == 3);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without a handshake", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one clock, noting what the channels moved at this edge
    task automatic tick();
        cmd_t done_cmd;
        @(posedge clk);
        req_taken = req_valid && req_ready;
        if (req_taken)
            outstanding.push_back(req.command);
        if (rsp_valid && rsp_ready && outstanding.size() != 0)
        begin
            done_cmd = outstanding.pop_front();
            if (done_cmd == CMD_ALLOC && rsp.success)
                owned.push_back(rsp.slot_out);
            else if (done_cmd == CMD_RESTART)
                owned.delete();
        end
    endtask

    task automatic send(input cmd_t c, input logic [SLOT_W-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) tick();
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_valid <= 1'b1;
        req <= '{command: c, slot_index: s};
        do
            tick();
        while (!req_taken);
    endtask

    task automatic wait_all_answered();
        req_valid <= 1'b0;
        burst_left = 0;
        while (outstanding.size() != 0)
            tick();
    endtask

    task automatic set_marks(input logic [MARK_W-1:0] low, input logic [MARK_W-1:0] high);
        cfg_en <= 1'b1;
        cfg_index <= REG_FREE_LOW_MARK;
        cfg_data <= low;
        tick();
        cfg_index <= REG_WRITTEN_HIGH_MARK;
        cfg_data <= high;
        tick();
        cfg_en <= 1'b0;
        mark_settings++;
    endtask

    // mostly producer-like traffic on slots we hold, plus some noise
    task automatic random_pool_op(output cmd_t c, output logic [SLOT_W-1:0] s);
        int roll;
        int k;
        roll = $urandom_range(0, 999);
        s = SLOT_W'($urandom_range(0, POOL - 1));
        c = CMD_ALLOC;
        if (roll < 150)
        begin
            c = cmd_t'($urandom_range(0, 7));
        end
        else if (roll < 155)
        begin
            c = CMD_RESTART;
        end
        else if (roll < 450)
        begin
            c = CMD_ALLOC;
        end
        else if (roll < 700)
        begin
            if (owned.size() != 0)
            begin
                k = $urandom_range(0, owned.size() - 1);
                s = owned[k];
                owned.delete(k);
                c = CMD_COMMIT;
                committed.push_back(s);
                if (committed.size() > HISTORY_DEPTH)
                    void'(committed.pop_front());
            end
        end
        else if (roll < 780)
        begin
            if (owned.size() != 0)
            begin
                k = $urandom_range(0, owned.size() - 1);
                s = owned[k];
                owned.delete(k);
                c = CMD_CANCEL;
            end
        end
        else if (roll < 850)
        begin
            c = CMD_SWAP;
        end
        else
        begin
            c = CMD_READ_LINK;
            if (committed.size() != 0 && roll < 960)
                s = committed[$urandom_range(0, committed.size() - 1)];
        end
    endtask

    initial
    begin
        logic [MARK_W-1:0] low_marks  [PHASES];
        logic [MARK_W-1:0] high_marks [PHASES];
        cmd_t              c;
        logic [SLOT_W-1:0] s;

        low_marks  = '{11'd0, 11'd1024, 11'd1024, 11'd0, 11'd0, 11'd1};
        high_marks = '{11'd0, 11'd1024, 11'd0, 11'd1024, 11'd0, 11'd1023};
        low_marks[4]  = MARK_W'($urandom_range(0, POOL));
        high_marks[4] = MARK_W'($urandom_range(0, POOL));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: list edges, misuse and unknown commands
        send(CMD_CANCEL, 10'd1023);     // free count already full, saturates
        send(CMD_ALLOC, 10'd0);
        send(CMD_ALLOC, 10'd1023);
        send(CMD_ALLOC, 10'd0);
        send(CMD_COMMIT, 10'd0);
        send(CMD_COMMIT, 10'd1023);
        send(CMD_READ_LINK, 10'd0);
        send(CMD_READ_LINK, 10'd1023);  // tail of written list, no link
        send(CMD_SWAP, 10'd0);
        send(CMD_READ_LINK, 10'd0);
        send(CMD_COMMIT, 10'd1);
        send(CMD_SWAP, 10'd0);          // reading list back to free
        send(CMD_CANCEL, 10'd5);
        send(CMD_COMMIT, 10'd5);        // free head now links to end mark
        send(CMD_ALLOC, 10'd0);
        send(CMD_ALLOC, 10'd0);         // broken free head, counts a drop
        send(CMD_CANCEL, 10'd700);
        send(CMD_ALLOC, 10'd0);
        send(cmd_t'(3'd6), 10'h2AA);
        send(cmd_t'(3'd7), 10'h155);
        send(CMD_READ_LINK, 10'h3FF);
        send(CMD_RESTART, 10'd0);
        send(CMD_ALLOC, 10'd0);
        send(CMD_SWAP, 10'd0);          // both lists empty

        // random traffic, first with the marks left at reset
        for (int p = 0; p <= PHASES; p++)
        begin
            if (p != 0)
            begin
                wait_all_answered();
                set_marks(low_marks[p - 1], high_marks[p - 1]);
            end
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                random_pool_op(c, s);
                send(c, s);
            end
        end

        // restart under fixed marks, then a short walk over both lists
        wait_all_answered();
        set_marks(11'd0, 11'd1023);
        send(CMD_RESTART, 10'($urandom_range(0, POOL - 1)));
        send(CMD_ALLOC, 10'd0);
        send(CMD_ALLOC, 10'd1023);
        send(CMD_COMMIT, 10'($urandom_range(0, POOL - 1)));
        send(CMD_COMMIT, 10'($urandom_range(0, POOL - 1)));
        send(CMD_SWAP, 10'd0);
        send(CMD_READ_LINK, 10'd0);
        send(CMD_READ_LINK, 10'd1023);
        send(CMD_SWAP, 10'd0);
        send(CMD_ALLOC, 10'd0);

        wait_all_answered();
        repeat (8) tick();

        if (pending_count != 0)
            $display("%0t: %0d expected responses never arrived", $time, pending_count);
        $display("covered %0d requests and %0d responses over %0d mark settings",
                 req_total, rsp_total, mark_settings);
        $display("including restarts, a broken free head, a saturated free count and unknown commands");
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
